// ===== sv/lcsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcsf_pkg
// Command codes shared by the longest common substring finder.
// ----------------------------------------------------------------------------
package lcsf_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_e;

  localparam int unsigned CharW = 8;

endpackage

// ===== sv/longest_common_substring_finder.sv =====
// ----------------------------------------------------------------------------
// longest_common_substring_finder
// Streams pattern then text bytes and reports the longest common substring.
//
//   channel | direction | payload                                      | accept
//   in      | input     | cmd, data_byte, last                         | in_valid & in_ready
//   out     | output    | match_length, text_offset, pattern_offset,   | out_valid & out_ready
//           |           | truncated                                    |
//
// A clear or pattern transaction completes as it is accepted. A text
// transaction walks the row of suffix lengths one cell per cycle through a
// single compare/add unit and a cell memory with one read and one write port.
// in_ready is low while a text byte is processed. A result waiting on a
// stalled output stalls only the end of the next text byte marked last.
// Reset clears counters and the best match; cell memory needs no clearing.
// ----------------------------------------------------------------------------
module longest_common_substring_finder
  import lcsf_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned TEXT_MAX    = 4096,
  localparam int unsigned CntW  = $clog2(PATTERN_MAX + 1),
  localparam int unsigned PidxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
  localparam int unsigned TxtW  = $clog2(TEXT_MAX)
) (
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [CharW-1:0] data_byte_i,
  input  logic             last_i,

  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CntW-1:0]  match_length_o,
  output logic [TxtW-1:0]  text_offset_o,
  output logic [PidxW-1:0] pattern_offset_o,
  output logic             truncated_o
);

  localparam int unsigned MemW = CharW + CntW;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Each cell holds a pattern byte and its current suffix length
  logic [MemW-1:0]  cell_mem [PATTERN_MAX];
  logic [MemW-1:0]  rd_data_q;

  state_e           state_q;
  logic [CntW-1:0]  pat_cnt_q;
  logic [TxtW-1:0]  txt_cnt_q;
  logic [CntW-1:0]  best_len_q;
  logic [TxtW-1:0]  best_txt_q;
  logic [PidxW-1:0] best_pat_q;
  logic             ovf_q;
  logic [CntW-1:0]  rd_idx_q;
  logic [PidxW-1:0] proc_idx_q;
  logic             v_q;
  logic [CntW-1:0]  prev_q;

  logic [CharW-1:0] ch_q;
  logic             last_q;
  logic [TxtW-1:0]  pos_q;

  logic             out_valid_q;
  logic [CntW-1:0]  out_len_q;
  logic [TxtW-1:0]  out_txt_q;
  logic [PidxW-1:0] out_pat_q;
  logic             out_trunc_q;

  logic             in_fire;
  logic             out_fire;
  logic             pat_room;
  logic             rd_go;
  logic             done;
  logic [CharW-1:0] cell_pat;
  logic [CntW-1:0]  cell_len;
  logic [CntW-1:0]  new_len;
  logic             better;
  logic [CntW-1:0]  pat_end;
  logic [TxtW:0]    txt_end;
  logic [PidxW-1:0] pat_start;
  logic [TxtW-1:0]  txt_start;
  logic             mem_we;
  logic [PidxW-1:0] mem_wa;
  logic [MemW-1:0]  mem_wd;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_fire   = out_valid_q & out_ready_i;
  assign pat_room   = (pat_cnt_q < CntW'(PATTERN_MAX));

  assign rd_go = (state_q == ST_RUN) && (rd_idx_q < pat_cnt_q);
  // Finish once the row is drained; a last byte also needs a free output slot
  assign done  = (state_q == ST_RUN) && !rd_go && !v_q &&
                 (!last_q || !out_valid_q || out_ready_i);

  assign cell_pat = rd_data_q[MemW-1 -: CharW];
  assign cell_len = rd_data_q[CntW-1:0];
  assign new_len  = (cell_pat == ch_q) ? prev_q + CntW'(1) : '0;
  assign better   = v_q && (new_len > best_len_q);

  // Start offsets: (index + 1 - len), floored at zero
  assign pat_end = CntW'(proc_idx_q) + CntW'(1);
  assign txt_end = {1'b0, pos_q} + (TxtW + 1)'(1);

  always_comb begin
    if (new_len > pat_end) begin
      pat_start = '0;
    end else begin
      pat_start = PidxW'(pat_end - new_len);
    end
    if ((TxtW + 1)'(new_len) > txt_end) begin
      txt_start = '0;
    end else begin
      txt_start = TxtW'(txt_end - (TxtW + 1)'(new_len));
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pat_cnt_q[PidxW-1:0];
    mem_wd = {data_byte_i, {CntW{1'b0}}};
    if (v_q) begin
      mem_we = 1'b1;
      mem_wa = proc_idx_q;
      mem_wd = {cell_pat, new_len};
    end else if (in_fire && (cmd_i == CMD_PATTERN) && pat_room) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_wa] <= mem_wd;
    end
    if (rd_go) begin
      rd_data_q <= cell_mem[rd_idx_q[PidxW-1:0]];
    end
  end

  // Hold the text byte under work
  always_ff @(posedge clk_i) begin
    if (in_fire && (cmd_i == CMD_TEXT)) begin
      ch_q   <= data_byte_i;
      last_q <= last_i;
      pos_q  <= txt_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pat_cnt_q   <= '0;
      txt_cnt_q   <= '0;
      best_len_q  <= '0;
      best_txt_q  <= '0;
      best_pat_q  <= '0;
      ovf_q       <= 1'b0;
      rd_idx_q    <= '0;
      proc_idx_q  <= '0;
      v_q         <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      out_len_q   <= '0;
      out_txt_q   <= '0;
      out_pat_q   <= '0;
      out_trunc_q <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (cmd_i)
              CMD_CLEAR: begin
                pat_cnt_q  <= '0;
                txt_cnt_q  <= '0;
                best_len_q <= '0;
                best_txt_q <= '0;
                best_pat_q <= '0;
                ovf_q      <= 1'b0;
              end
              CMD_PATTERN: begin
                if (pat_room) begin
                  pat_cnt_q <= pat_cnt_q + CntW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              CMD_TEXT: begin
                if (txt_cnt_q < TxtW'(TEXT_MAX - 1)) begin
                  txt_cnt_q <= txt_cnt_q + TxtW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
                rd_idx_q <= '0;
                v_q      <= 1'b0;
                prev_q   <= '0;
                state_q  <= ST_RUN;
              end
              default: begin
                // unused command: drop
              end
            endcase
          end
        end
        ST_RUN: begin
          v_q <= rd_go;
          if (rd_go) begin
            proc_idx_q <= rd_idx_q[PidxW-1:0];
            rd_idx_q   <= rd_idx_q + CntW'(1);
          end
          if (v_q) begin
            prev_q <= cell_len;
          end
          if (better) begin
            best_len_q <= new_len;
            best_pat_q <= pat_start;
            best_txt_q <= txt_start;
          end
          if (done) begin
            state_q <= ST_IDLE;
            if (last_q) begin
              out_valid_q <= 1'b1;
              out_len_q   <= best_len_q;
              out_txt_q   <= best_txt_q;
              out_pat_q   <= best_pat_q;
              out_trunc_q <= ovf_q;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_length_o   = out_len_q;
  assign text_offset_o    = out_txt_q;
  assign pattern_offset_o = out_pat_q;
  assign truncated_o      = out_trunc_q;

endmodule
